/* hdl/ptb_pkg.sv */
// ptb_pkg: op, status and kind codes, field widths and shared types for the
// periodic timer bank. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

  // field widths of the beat payloads
  localparam int OP_W     = 3;
  localparam int XID_W    = 16;
  localparam int XIVAL_W  = 24;
  localparam int STATUS_W = 3;

  // most expiries reported for one tick
  localparam int MAX_RESULTS = 16;

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
  localparam logic [OP_W-1:0] OP_START  = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
  localparam logic [OP_W-1:0] OP_SETIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_TERM   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADIVAL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDS_EXH  = 3'd4;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // operand selection of the shared compare unit
  typedef enum logic {
    UNIT_ID,   // slot id against target or best id
    UNIT_CNT   // count + 1 against interval
  } unit_mode_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_flags_t;

endpackage

`default_nettype wire

/* hdl/periodic_timer_bank.sv */
// periodic_timer_bank: top level, sequencer and result register of the
// timer bank. Uses ptb_pkg, ptb_slot_mem and ptb_unit.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_ready    op, timer_id, interval, start_now
// out_     out  out_valid/out_ready  kind, result_id, status, last
//
// Flow (N = NUM_TIMERS): every slot visit through the entry memory has an
// address step and a registered read step, all through the one compare unit.
// Command: decode, then the id search over up to N slots (create walks
// the valid flops, one slot a cycle), then the result beat is loaded; bad
// intervals answer after decode.
// Tick: a count pass over all N slots, then one smallest-id search over all
// N slots per expiry. in_ready is high only while the sequencer is idle.
// Reset clears valid flops, next id and the sequencer; the entry memory is
// never cleared. A stalled out_ready holds the result beat in the output
// register; the sequencer waits only when its next beat has nowhere to go.

module periodic_timer_bank #(
  parameter int NUM_TIMERS  = 16,
  parameter int ID_WIDTH    = 16,
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ptb_pkg::OP_W-1:0]      in_op,
  input  wire logic [ptb_pkg::XID_W-1:0]     in_timer_id,
  input  wire logic [ptb_pkg::XIVAL_W-1:0]   in_interval,
  input  wire logic                          in_start_now,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_kind,
  output logic      [ptb_pkg::XID_W-1:0]     out_result_id,
  output logic      [ptb_pkg::STATUS_W-1:0]  out_status,
  output logic                               out_last
);
  import ptb_pkg::*;

  localparam int IW    = ID_WIDTH;
  localparam int CW    = COUNT_WIDTH;
  localparam int IDXW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int RW    = $clog2(NUM_TIMERS + 1);
  localparam int ENT_W = 1 + IW + 2 * CW;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_TIMERS - 1);

  // entry layout: {enabled, id, interval, count}
  localparam int CNT_LO = 0;
  localparam int IV_LO  = CW;
  localparam int ID_LO  = 2 * CW;
  localparam int EN_BIT = ENT_W - 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_FREE   = 4'd2;
  localparam logic [3:0] S_TK_RD  = 4'd3;
  localparam logic [3:0] S_TK_CHK = 4'd4;
  localparam logic [3:0] S_FD_RD  = 4'd5;
  localparam logic [3:0] S_FD_CHK = 4'd6;
  localparam logic [3:0] S_SR_RD  = 4'd7;
  localparam logic [3:0] S_SR_CHK = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [IDXW-1:0]       idx_r, idx_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [IW-1:0]         tgt_r, tgt_nxt;
  logic [CW-1:0]         ival_r, ival_nxt;
  logic                  ival_bad_r, ival_bad_nxt;
  logic                  start_now_r, start_now_nxt;
  logic [NUM_TIMERS-1:0] fired_r, fired_nxt;
  logic [RW-1:0]         fire_cnt_r, fire_cnt_nxt;
  logic [RW-1:0]         remain_r, remain_nxt;
  logic [IW-1:0]         best_id_r, best_id_nxt;
  logic [IDXW-1:0]       best_idx_r, best_idx_nxt;
  logic                  have_best_r, have_best_nxt;
  logic [IW-1:0]         next_id_r, next_id_nxt;
  logic                  res_kind_r, res_kind_nxt;
  logic [XID_W-1:0]      res_id_r, res_id_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic                  res_last_r, res_last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic [XID_W-1:0]      out_id_r, out_id_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  // memory and unit hookup
  logic                  mem_we;
  logic [ENT_W-1:0]      mem_wdata;
  logic [ENT_W-1:0]      rd_ent;
  logic                  vld_set;
  logic                  vld_clr;
  logic [NUM_TIMERS-1:0] vld;
  unit_mode_t            u_mode;
  logic [IW-1:0]         u_id_b;
  logic [CW-1:0]         u_inc;
  cmp_flags_t            u_flags;

  logic [CW-1:0]         ent_cnt;
  logic [CW-1:0]         ent_ival;
  logic [IW-1:0]         ent_id;
  logic                  ent_en;
  logic                  out_free;
  logic [31:0]           in_id32;
  logic [31:0]           in_iv32;
  logic [31:0]           tgt32;

  assign ent_cnt  = rd_ent[CNT_LO +: CW];
  assign ent_ival = rd_ent[IV_LO +: CW];
  assign ent_id   = rd_ent[ID_LO +: IW];
  assign ent_en   = rd_ent[EN_BIT];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // input id masked to the id width, interval widened for the range check
  assign in_id32 = {16'd0, in_timer_id};
  assign in_iv32 = {8'd0, in_interval};
  assign tgt32   = 32'(tgt_r);

  assign u_mode = (state_r == S_TK_CHK) ? UNIT_CNT : UNIT_ID;
  assign u_id_b = (state_r == S_SR_CHK) ? best_id_r : tgt_r;

  ptb_slot_mem #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (ENT_W),
    .AW    (IDXW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .raddr   (idx_r),
    .rdata   (rd_ent),
    .we      (mem_we),
    .waddr   (idx_r),
    .wdata   (mem_wdata),
    .vld_set (vld_set),
    .vld_clr (vld_clr),
    .vld_idx (idx_r),
    .vld     (vld)
  );

  ptb_unit #(
    .IW (IW),
    .CW (CW)
  ) u_unit (
    .mode  (u_mode),
    .id_a  (ent_id),
    .id_b  (u_id_b),
    .cnt   (ent_cnt),
    .ival  (ent_ival),
    .inc   (u_inc),
    .flags (u_flags)
  );

  always_comb begin
    logic          hit;
    logic          fire;
    logic          take;
    logic [RW-1:0] fc;
    logic [IW-1:0] sel_id;
    logic [IDXW-1:0] sel_idx;
    logic [IW-1:0] nid;
    logic [31:0]   id32;

    state_nxt      = state_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    tgt_nxt        = tgt_r;
    ival_nxt       = ival_r;
    ival_bad_nxt   = ival_bad_r;
    start_now_nxt  = start_now_r;
    fired_nxt      = fired_r;
    fire_cnt_nxt   = fire_cnt_r;
    remain_nxt     = remain_r;
    best_id_nxt    = best_id_r;
    best_idx_nxt   = best_idx_r;
    have_best_nxt  = have_best_r;
    next_id_nxt    = next_id_r;
    res_kind_nxt   = res_kind_r;
    res_id_nxt     = res_id_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_wdata      = rd_ent;
    vld_set        = 1'b0;
    vld_clr        = 1'b0;

    hit     = 1'b0;
    fire    = !u_flags.lt;
    take    = fired_r[idx_r] && (!have_best_r || u_flags.lt);
    fc      = fire_cnt_r;
    sel_id  = take ? ent_id : best_id_r;
    sel_idx = take ? idx_r : best_idx_r;
    nid     = next_id_r + {{(IW-1){1'b0}}, 1'b1};
    id32    = 32'(nid);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_op;
          tgt_nxt       = in_id32[IW-1:0];
          ival_nxt      = in_iv32[CW-1:0];
          ival_bad_nxt  = (in_interval == '0) || ((in_iv32 >> CW) != 32'd0);
          start_now_nxt = in_start_now;
          state_nxt     = S_DECODE;
        end
      end

      S_DECODE: begin
        idx_nxt = '0;
        unique case (op_r) inside
          OP_TICK: begin
            fired_nxt    = '0;
            fire_cnt_nxt = '0;
            state_nxt    = S_TK_RD;
          end
          OP_CREATE: begin
            if (ival_bad_r) begin
              res_kind_nxt   = KIND_STATUS;
              res_id_nxt     = '0;
              res_status_nxt = ST_BADIVAL;
              res_last_nxt   = 1'b1;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_FREE;
            end
          end
          OP_SETIV: begin
            if (ival_bad_r) begin
              res_kind_nxt   = KIND_STATUS;
              res_id_nxt     = tgt32[XID_W-1:0];
              res_status_nxt = ST_BADIVAL;
              res_last_nxt   = 1'b1;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_FD_RD;
            end
          end
          OP_START, OP_STOP, OP_TERM: begin
            state_nxt = S_FD_RD;
          end
          default: begin
            // undefined ops do nothing and answer nothing
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_FREE: begin
        res_kind_nxt = KIND_STATUS;
        res_last_nxt = 1'b1;
        if (!vld[idx_r]) begin
          if (&next_id_r) begin
            res_id_nxt     = '0;
            res_status_nxt = ST_IDS_EXH;
          end else begin
            next_id_nxt    = nid;
            mem_we         = 1'b1;
            mem_wdata      = {start_now_r, nid, ival_r, {CW{1'b0}}};
            vld_set        = 1'b1;
            res_id_nxt     = id32[XID_W-1:0];
            res_status_nxt = ST_OK;
          end
          state_nxt = S_RESP;
        end else if (idx_r == LAST_IDX) begin
          res_id_nxt     = '0;
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_TK_RD: state_nxt = S_TK_CHK;

      S_TK_CHK: begin
        if (vld[idx_r] && ent_en) begin
          mem_we    = 1'b1;
          mem_wdata = {ent_en, ent_id, ent_ival, (fire ? {CW{1'b0}} : u_inc)};
          if (fire) begin
            fired_nxt[idx_r] = 1'b1;
            fc = fire_cnt_r + 1'b1;
          end
        end
        fire_cnt_nxt = fc;
        if (idx_r == LAST_IDX) begin
          idx_nxt       = '0;
          have_best_nxt = 1'b0;
          if (fc == '0) begin
            state_nxt = S_IDLE;
          end else begin
            remain_nxt = (32'(fc) > MAX_RESULTS) ? RW'(MAX_RESULTS) : fc;
            state_nxt  = S_SR_RD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TK_RD;
        end
      end

      S_FD_RD: state_nxt = S_FD_CHK;

      S_FD_CHK: begin
        hit          = vld[idx_r] && u_flags.eq;
        res_kind_nxt = KIND_STATUS;
        res_id_nxt   = tgt32[XID_W-1:0];
        res_last_nxt = 1'b1;
        if (hit) begin
          unique case (op_r) inside
            OP_START, OP_STOP: begin
              mem_we    = 1'b1;
              mem_wdata = {(op_r == OP_START), ent_id, ent_ival, ent_cnt};
            end
            OP_SETIV: begin
              mem_we    = 1'b1;
              mem_wdata = {ent_en, ent_id, ival_r, ent_cnt};
            end
            default: vld_clr = 1'b1;
          endcase
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_FD_RD;
        end
      end

      S_SR_RD: state_nxt = S_SR_CHK;

      S_SR_CHK: begin
        best_id_nxt   = sel_id;
        best_idx_nxt  = sel_idx;
        have_best_nxt = have_best_r || take;
        if (idx_r == LAST_IDX) begin
          id32               = 32'(sel_id);
          res_kind_nxt       = KIND_EXPIRY;
          res_id_nxt         = id32[XID_W-1:0];
          res_status_nxt     = ST_OK;
          res_last_nxt       = (remain_r == RW'(1));
          fired_nxt[sel_idx] = 1'b0;
          remain_nxt         = remain_r - 1'b1;
          state_nxt          = S_RESP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SR_RD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = res_kind_r;
          out_id_nxt     = res_id_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = res_last_r;
          if (res_kind_r == KIND_EXPIRY && remain_r != '0) begin
            idx_nxt       = '0;
            have_best_nxt = 1'b0;
            state_nxt     = S_SR_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
      remain_r    <= '0;
      have_best_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      remain_r    <= remain_nxt;
      have_best_r <= have_best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    tgt_r        <= tgt_nxt;
    ival_r       <= ival_nxt;
    ival_bad_r   <= ival_bad_nxt;
    start_now_r  <= start_now_nxt;
    fired_r      <= fired_nxt;
    fire_cnt_r   <= fire_cnt_nxt;
    best_id_r    <= best_id_nxt;
    best_idx_r   <= best_idx_nxt;
    res_kind_r   <= res_kind_nxt;
    res_id_r     <= res_id_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_result_id = out_id_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  // an accepted beat is always decoded next
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted beat not decoded");

  // a pending result is loaded as soon as the output register frees up
  a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_free) |=> out_valid_r)
    else $error("result beat not loaded");

  // expiry beats always carry ok status
  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_EXPIRY) |-> (out_status_r == ST_OK))
    else $error("expiry beat with non-ok status");

  // the expiry search only runs with beats still owed
  a_search_owed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SR_CHK) |-> (remain_r != '0))
    else $error("expiry search with nothing owed");
`endif

endmodule

`default_nettype wire

/* hdl/ptb_slot_mem.sv */
// ptb_slot_mem: slot entry memory (one write, one registered read) plus
// the per-slot valid flops. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ptb_slot_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 65,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             vld_set,
  input  wire logic             vld_clr,
  input  wire logic [AW-1:0]    vld_idx,
  output logic      [DEPTH-1:0] vld
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (vld_set) begin
      vld_r[vld_idx] <= 1'b1;
    end else if (vld_clr) begin
      vld_r[vld_idx] <= 1'b0;
    end
  end

  assign rdata = rdata_r;
  assign vld   = vld_r;

endmodule

`default_nettype wire

/* hdl/ptb_unit.sv */
// ptb_unit: shared compare unit with count incrementer; one subtract serves
// id match, id ordering and the expiry test. Uses ptb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptb_unit #(
  parameter int IW = 16,
  parameter int CW = 24
) (
  input  wire ptb_pkg::unit_mode_t mode,
  input  wire logic [IW-1:0]       id_a,
  input  wire logic [IW-1:0]       id_b,
  input  wire logic [CW-1:0]       cnt,
  input  wire logic [CW-1:0]       ival,
  output logic      [CW-1:0]       inc,
  output ptb_pkg::cmp_flags_t      flags
);
  import ptb_pkg::*;

  localparam int OW = (IW > CW + 1) ? IW : CW + 1;

  logic [CW:0]   inc_full;
  logic [OW-1:0] opa;
  logic [OW-1:0] opb;
  logic [OW:0]   diff;

  assign inc_full = {1'b0, cnt} + {{CW{1'b0}}, 1'b1};
  assign inc      = inc_full[CW-1:0];

  always_comb begin
    unique case (mode)
      UNIT_CNT: begin
        opa = OW'(inc_full);
        opb = OW'(ival);
      end
      default: begin
        opa = OW'(id_a);
        opb = OW'(id_b);
      end
    endcase
  end

  assign diff     = {1'b0, opa} - {1'b0, opb};
  assign flags.lt = diff[OW];
  assign flags.eq = (diff[OW-1:0] == '0);

endmodule

`default_nettype wire
